// ----- sv/cfata_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube face atlas tile allocator package
// Shared field widths, request codes, status codes and the level result type.
// ----------------------------------------------------------------------------
package cfata_pkg;

   localparam int NUM_FACES   = 6;
   localparam int FACE_W      = 3;
   localparam int ACTION_W    = 2;
   localparam int RECT_W      = 14;
   localparam int LEVEL_W     = 2;
   localparam int TILE_X_W    = 11;
   localparam int TILE_Y_W    = 10;
   localparam int TILE_SIZE_W = 10;

   // Rectangle edges saturate at this many pixels.
   localparam logic [RECT_W-1:0]  RECT_SAT  = 14'd8192;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 2'd3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SET_BOUNDS = 2'd0,
      ACT_CLEAR      = 2'd1,
      ACT_ALLOCATE   = 2'd2
   } action_type;

   typedef enum logic {
      STATUS_OK       = 1'b0,
      STATUS_NO_SPACE = 1'b1
   } status_type;

   // Result of the detail level unit, valid for one cycle when done is set.
   typedef struct packed {
      logic                done;
      logic [LEVEL_W-1:0]  level;
   } level_result_type;

endpackage

// ----- sv/cfata_level_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detail level unit
// Saturates the rectangle, multiplies it out and turns the capped area into a
// detail level of 0 to 3 with three constant threshold compares.
// ----------------------------------------------------------------------------
module cfata_level_unit #(
   parameter int ATLAS_WIDTH  = 2048,
   parameter int ATLAS_HEIGHT = 1024,
   parameter int LOG_MAX_FACE = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cfata_pkg::RECT_W-1:0]        rect_width,
   input  logic [cfata_pkg::RECT_W-1:0]        rect_height,
   output cfata_pkg::level_result_type         result
);

   localparam int PROD_W = 2 * cfata_pkg::RECT_W;
   localparam int TWICE_W = PROD_W + 1;

   localparam logic [PROD_W-1:0]  AREA_CAP = PROD_W'(ATLAS_WIDTH * ATLAS_HEIGHT);
   // Twice the area must not exceed 6 * 4^mip; mip at most LOG_MAX_FACE - k
   // gives a level of at least k.
   localparam logic [TWICE_W-1:0] THRESH_L1 = TWICE_W'(6 << (2 * (LOG_MAX_FACE - 1)));
   localparam logic [TWICE_W-1:0] THRESH_L2 = TWICE_W'(6 << (2 * (LOG_MAX_FACE - 2)));
   localparam logic [TWICE_W-1:0] THRESH_L3 = TWICE_W'(6 << (2 * (LOG_MAX_FACE - 3)));

   logic [cfata_pkg::RECT_W-1:0]  width_sat;
   logic [cfata_pkg::RECT_W-1:0]  height_sat;
   logic [PROD_W-1:0]             prod_ff;
   logic [PROD_W-1:0]             prod_in;
   logic                          prod_valid_ff;
   logic [PROD_W-1:0]             area_capped;
   logic [TWICE_W-1:0]            area_twice;
   logic [cfata_pkg::LEVEL_W-1:0] level_ff;
   logic [cfata_pkg::LEVEL_W-1:0] level_in;
   logic                          done_ff;

   always_comb begin
      width_sat  = (rect_width > cfata_pkg::RECT_SAT) ? cfata_pkg::RECT_SAT : rect_width;
      height_sat = (rect_height > cfata_pkg::RECT_SAT) ? cfata_pkg::RECT_SAT : rect_height;
      prod_in    = {{cfata_pkg::RECT_W{1'b0}}, width_sat}
                 * {{cfata_pkg::RECT_W{1'b0}}, height_sat};
   end

   always_comb begin
      area_capped = (prod_ff > AREA_CAP) ? AREA_CAP : prod_ff;
      area_twice  = {area_capped, 1'b0};
      priority if (area_twice <= THRESH_L3) begin
         level_in = cfata_pkg::MAX_LEVEL;
      end else if (area_twice <= THRESH_L2) begin
         level_in = 2'd2;
      end else if (area_twice <= THRESH_L1) begin
         level_in = 2'd1;
      end else begin
         level_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      level_ff <= level_in;
      if (reset) begin
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         prod_valid_ff <= start;
         done_ff       <= prod_valid_ff;
      end
   end

   assign result.done  = done_ff;
   assign result.level = level_ff;

endmodule

// ----- sv/cfata_overlap_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap checker
// Tests one candidate tile against the tiles of all other allocated faces in
// parallel and reports whether the position is free.
// ----------------------------------------------------------------------------
module cfata_overlap_check #(
   parameter int CW = 14
) (
   input  logic [CW-1:0]                          cand_x,
   input  logic [CW-1:0]                          cand_y,
   input  logic [CW-1:0]                          cand_size,
   input  logic [cfata_pkg::FACE_W-1:0]           face,
   input  logic [cfata_pkg::NUM_FACES-1:0]        face_allocated,
   input  logic [CW-1:0]                          tile_x    [cfata_pkg::NUM_FACES],
   input  logic [CW-1:0]                          tile_y    [cfata_pkg::NUM_FACES],
   input  logic [CW-1:0]                          tile_size [cfata_pkg::NUM_FACES],
   output logic                                   position_free
);

   logic [cfata_pkg::NUM_FACES-1:0] hit;

   // Coordinate plus edge always fits in CW bits, so the sums do not wrap.
   always_comb begin
      for (int p = 0; p < cfata_pkg::NUM_FACES; p++) begin
         hit[p] = face_allocated[p]
               && (face != cfata_pkg::FACE_W'(p))
               && (cand_y < tile_y[p] + tile_size[p])
               && (cand_x < tile_x[p] + tile_size[p])
               && (cand_y + cand_size > tile_y[p])
               && (cand_x + cand_size > tile_x[p]);
      end
      position_free = ~|hit;
   end

endmodule

// ----- sv/cube_face_atlas_tile_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube face atlas tile allocator
// Places one square tile per cube face in a 2D atlas, first fit, and picks the
// detail level that sets the tile edge from a screen rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) takes one command per
//   transfer: set bounds, clear all tiles, or allocate a tile for a face.
//   Every request yields exactly one transfer on the response channel
//   (rsp_valid / rsp_stall) with status, tile placement and current level.
//   The block works on one request at a time and stalls the request channel
//   until that request's response has been loaded into the output register.
//   Path from request transfer to response valid, each ending in the done
//   state and then the output register:
//     clear, unused codes, bad face, face already placed: done state only;
//     set bounds: the level unit (saturate and multiply, threshold compares);
//     allocation scan: N grid positions probed, one per cycle through the
//     overlap checker. N is at most (ATLAS_WIDTH / edge) * (ATLAS_HEIGHT / edge),
//     rounded up, which is 512 at level 3 with the default atlas.
//   The output register frees the block to take the next request while a
//   response still waits; a stalled response holds until it is taken.
//   Reset (synchronous) frees all faces, sets the level to 0 and turns
//   reallocation on. The csr port may be written only while the block idles.
// ----------------------------------------------------------------------------
module cube_face_atlas_tile_allocator_unit #(
   parameter int ATLAS_WIDTH  = 2048,
   parameter int ATLAS_HEIGHT = 1024,
   parameter int LOG_MAX_FACE = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cfata_pkg::ACTION_W-1:0]      req_action,
   input  logic [cfata_pkg::FACE_W-1:0]        req_face,
   input  logic [cfata_pkg::RECT_W-1:0]        req_rect_width,
   input  logic [cfata_pkg::RECT_W-1:0]        req_rect_height,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic [cfata_pkg::TILE_X_W-1:0]      rsp_tile_x,
   output logic [cfata_pkg::TILE_Y_W-1:0]      rsp_tile_y,
   output logic [cfata_pkg::TILE_SIZE_W-1:0]   rsp_tile_size,
   output logic [cfata_pkg::LEVEL_W-1:0]       rsp_detail_level
);

   // Coordinate width: large enough for any position plus a full tile edge,
   // and never narrower than the widest tile field of the response.
   localparam int MAX_DIM = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
   localparam int CW_RAW  = $clog2(MAX_DIM + (1 << LOG_MAX_FACE)) + 1;
   localparam int CW      = (CW_RAW < cfata_pkg::TILE_X_W) ? cfata_pkg::TILE_X_W : CW_RAW;
   localparam int NF      = cfata_pkg::NUM_FACES;

   localparam logic [CW-1:0] ATLAS_W_C   = CW'(ATLAS_WIDTH);
   localparam logic [CW-1:0] ATLAS_H_C   = CW'(ATLAS_HEIGHT);
   localparam logic [CW-1:0] MAX_EDGE_C  = CW'(1) << LOG_MAX_FACE;
   localparam logic [cfata_pkg::FACE_W-1:0] LAST_FACE = cfata_pkg::FACE_W'(NF - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Control and configuration registers.
   state_type                      state_ff,        state_in;
   logic                           realloc_en_ff,   realloc_en_in;
   logic [NF-1:0]                  alloc_ff,        alloc_in;
   logic [cfata_pkg::LEVEL_W-1:0]  level_ff,        level_in;
   logic                           rsp_valid_ff,    rsp_valid_in;

   // Face placement store; an entry is only read once its face is allocated.
   logic [CW-1:0]                  tx_ff [NF];
   logic [CW-1:0]                  tx_in [NF];
   logic [CW-1:0]                  ty_ff [NF];
   logic [CW-1:0]                  ty_in [NF];
   logic [CW-1:0]                  ts_ff [NF];
   logic [CW-1:0]                  ts_in [NF];

   // Scan and result working registers.
   logic [cfata_pkg::FACE_W-1:0]   face_ff,         face_in;
   logic [CW-1:0]                  cand_x_ff,       cand_x_in;
   logic [CW-1:0]                  cand_y_ff,       cand_y_in;
   logic [CW-1:0]                  edge_ff,         edge_in;
   logic                           res_status_ff,   res_status_in;
   logic [CW-1:0]                  res_x_ff,        res_x_in;
   logic [CW-1:0]                  res_y_ff,        res_y_in;
   logic [CW-1:0]                  res_size_ff,     res_size_in;

   // Output register.
   logic                                rsp_status_ff,   rsp_status_in;
   logic [cfata_pkg::TILE_X_W-1:0]      rsp_x_ff,        rsp_x_in;
   logic [cfata_pkg::TILE_Y_W-1:0]      rsp_y_ff,        rsp_y_in;
   logic [cfata_pkg::TILE_SIZE_W-1:0]   rsp_size_ff,     rsp_size_in;
   logic [cfata_pkg::LEVEL_W-1:0]       rsp_level_ff,    rsp_level_in;

   logic                           req_xfer;
   logic                           out_free;
   logic                           position_free;
   logic [CW-1:0]                  next_x;
   logic [CW-1:0]                  next_y;
   cfata_pkg::level_result_type    level_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   // The output register can take a new response when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   cfata_level_unit #(
      .ATLAS_WIDTH  (ATLAS_WIDTH),
      .ATLAS_HEIGHT (ATLAS_HEIGHT),
      .LOG_MAX_FACE (LOG_MAX_FACE)
   ) u_level (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer && (req_action == cfata_pkg::ACT_SET_BOUNDS)),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .result      (level_result)
   );

   cfata_overlap_check #(
      .CW (CW)
   ) u_overlap (
      .cand_x         (cand_x_ff),
      .cand_y         (cand_y_ff),
      .cand_size      (edge_ff),
      .face           (face_ff),
      .face_allocated (alloc_ff),
      .tile_x         (tx_ff),
      .tile_y         (ty_ff),
      .tile_size      (ts_ff),
      .position_free  (position_free)
   );

   assign next_x = cand_x_ff + edge_ff;
   assign next_y = cand_y_ff + edge_ff;

   always_comb begin
      state_in      = state_ff;
      realloc_en_in = csr_write_enable ? csr_write_data : realloc_en_ff;
      alloc_in      = alloc_ff;
      level_in      = level_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      ts_in         = ts_ff;
      face_in       = face_ff;
      cand_x_in     = cand_x_ff;
      cand_y_in     = cand_y_ff;
      edge_in       = edge_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_level_in  = rsp_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // Default answer: ok with zero tile fields.
               res_status_in = cfata_pkg::STATUS_OK;
               res_x_in      = '0;
               res_y_in      = '0;
               res_size_in   = '0;
               face_in       = req_face;
               state_in      = ST_DONE;
               unique case (cfata_pkg::action_type'(req_action))
                  cfata_pkg::ACT_SET_BOUNDS: begin
                     state_in = ST_LEVEL;
                  end
                  cfata_pkg::ACT_CLEAR: begin
                     if (realloc_en_ff) begin
                        alloc_in = '0;
                     end
                  end
                  cfata_pkg::ACT_ALLOCATE: begin
                     priority if (req_face > LAST_FACE) begin
                        res_status_in = cfata_pkg::STATUS_NO_SPACE;
                     end else if (alloc_ff[req_face]) begin
                        // The face keeps the tile it already holds.
                        res_x_in    = tx_ff[req_face];
                        res_y_in    = ty_ff[req_face];
                        res_size_in = ts_ff[req_face];
                     end else begin
                        cand_x_in = '0;
                        cand_y_in = '0;
                        edge_in   = MAX_EDGE_C >> level_ff;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                     // Unused code: ok answer, no change to faces or level.
                  end
               endcase
            end
         end
         ST_LEVEL: begin
            if (level_result.done) begin
               level_in = realloc_en_ff ? level_result.level : '0;
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            // One grid position per cycle: y inner, x outer.
            priority if (position_free) begin
               alloc_in[face_ff] = 1'b1;
               tx_in[face_ff]    = cand_x_ff;
               ty_in[face_ff]    = cand_y_ff;
               ts_in[face_ff]    = edge_ff;
               res_x_in          = cand_x_ff;
               res_y_in          = cand_y_ff;
               res_size_in       = edge_ff;
               state_in          = ST_DONE;
            end else if (next_y < ATLAS_H_C) begin
               cand_y_in = next_y;
            end else if (next_x < ATLAS_W_C) begin
               cand_y_in = '0;
               cand_x_in = next_x;
            end else begin
               res_status_in = cfata_pkg::STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in      = res_x_ff[cfata_pkg::TILE_X_W-1:0];
               rsp_y_in      = res_y_ff[cfata_pkg::TILE_Y_W-1:0];
               rsp_size_in   = res_size_ff[cfata_pkg::TILE_SIZE_W-1:0];
               rsp_level_in  = level_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      ts_ff         <= ts_in;
      face_ff       <= face_in;
      cand_x_ff     <= cand_x_in;
      cand_y_ff     <= cand_y_in;
      edge_ff       <= edge_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_level_ff  <= rsp_level_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         realloc_en_ff <= 1'b1;
         alloc_ff      <= '0;
         level_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         realloc_en_ff <= realloc_en_in;
         alloc_ff      <= alloc_in;
         level_ff      <= level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_tile_x       = rsp_x_ff;
   assign rsp_tile_y       = rsp_y_ff;
   assign rsp_tile_size    = rsp_size_ff;
   assign rsp_detail_level = rsp_level_ff;

   // A response only appears after the sequencer has finished a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the completion state");

   // The scan never probes a position outside the atlas.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cand_x_ff < ATLAS_W_C) && (cand_y_ff < ATLAS_H_C))
      else $error("scan candidate left the atlas");

   // At most one face gains a tile per cycle, and only from the scan.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(alloc_ff & ~$past(alloc_ff)))
      else $error("more than one face allocated in one cycle");

   assert property (@(posedge clock) disable iff (reset)
      ((alloc_ff & ~$past(alloc_ff)) != '0) |-> $past(state_ff == ST_SCAN))
      else $error("face allocated outside the scan");

endmodule

// ----- tb/sv/cube_face_atlas_tile_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube face atlas tile allocator testbench
// Drives bounds, clear, allocate and unused commands into the allocator with
// random gaps and response back-pressure. Each response is compared field by
// field with a typed reply or a behavioral copy of the placement and level pick.
// ----------------------------------------------------------------------------
module cube_face_atlas_tile_allocator_unit_tb;

   localparam int ATLAS_W      = 2048;
   localparam int ATLAS_H      = 1024;
   localparam int LOG_MAX      = 9;
   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 11;

   // The longest single command is a full scan at level 3 over 512 positions.
   // The watchdog allows that scan plus the longest stall and sender gap
   // many times over before it declares the run hung.
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 520;
   localparam int ITEMS_PER_PHASE = 256;

   // Code 3 is not a command; the block must answer it with an empty reply.
   localparam logic [cfata_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      cfata_pkg::status_type                status;
      logic [cfata_pkg::TILE_X_W-1:0]       tile_x;
      logic [cfata_pkg::TILE_Y_W-1:0]       tile_y;
      logic [cfata_pkg::TILE_SIZE_W-1:0]    tile_size;
      logic [cfata_pkg::LEVEL_W-1:0]        level;
   } tile_reply_type;

   // One command. When typed is set, reply holds an expectation written out
   // by hand in the directed table instead of the predicted one.
   typedef struct {
      logic [cfata_pkg::ACTION_W-1:0]       action;
      logic [cfata_pkg::FACE_W-1:0]         face;
      logic [cfata_pkg::RECT_W-1:0]         width;
      logic [cfata_pkg::RECT_W-1:0]         height;
      bit                                   typed;
      tile_reply_type                       reply;
   } atlas_command_type;

   // ------------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value from time 0.
   // ------------------------------------------------------------------------
   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic                                csr_write_data   = 1'b0;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   logic [cfata_pkg::ACTION_W-1:0]      req_action       = '0;
   logic [cfata_pkg::FACE_W-1:0]        req_face         = '0;
   logic [cfata_pkg::RECT_W-1:0]        req_rect_width   = '0;
   logic [cfata_pkg::RECT_W-1:0]        req_rect_height  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic                                rsp_status;
   logic [cfata_pkg::TILE_X_W-1:0]      rsp_tile_x;
   logic [cfata_pkg::TILE_Y_W-1:0]      rsp_tile_y;
   logic [cfata_pkg::TILE_SIZE_W-1:0]   rsp_tile_size;
   logic [cfata_pkg::LEVEL_W-1:0]       rsp_detail_level;

   always #(CLK_PERIOD / 2) clock = ~clock;

   cube_face_atlas_tile_allocator_unit #(
      .ATLAS_WIDTH  (ATLAS_W),
      .ATLAS_HEIGHT (ATLAS_H),
      .LOG_MAX_FACE (LOG_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_face         (req_face),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_size    (rsp_tile_size),
      .rsp_detail_level (rsp_detail_level)
   );

   // ------------------------------------------------------------------------
   // Allocator predictor. Its state mirrors the block after reset: no face
   // placed, level 0, reallocation on. The tile coordinates of a face are
   // only read once that face has been placed.
   // ------------------------------------------------------------------------
   bit                            reallocate_on = 1'b1;
   bit                            face_placed [cfata_pkg::NUM_FACES] = '{default: 1'b0};
   int                            face_x      [cfata_pkg::NUM_FACES];
   int                            face_y      [cfata_pkg::NUM_FACES];
   int                            face_size   [cfata_pkg::NUM_FACES];
   logic [cfata_pkg::LEVEL_W-1:0] atlas_level  = '0;

   tile_reply_type     pending_replies [$];
   atlas_command_type  directed_rows   [$];
   tile_reply_type     oldest_reply;
   int                 mismatch_count = 0;
   int                 quiet_cycles   = 0;

   // The level comes from the saturated rectangle area: find the smallest
   // mip whose six faces of 4^mip texels cover twice that area, then count
   // down from the largest face size. Reallocation off pins the level at 0.
   function automatic logic [cfata_pkg::LEVEL_W-1:0] level_for_rect(
         logic [cfata_pkg::RECT_W-1:0] rw, logic [cfata_pkg::RECT_W-1:0] rh);
      longint unsigned w;
      longint unsigned h;
      longint unsigned area;
      int              mip;
      int              lvl;
      w    = (rw > cfata_pkg::RECT_SAT) ? cfata_pkg::RECT_SAT : rw;
      h    = (rh > cfata_pkg::RECT_SAT) ? cfata_pkg::RECT_SAT : rh;
      area = w * h;
      if (area > longint'(ATLAS_W) * ATLAS_H) begin
         area = longint'(ATLAS_W) * ATLAS_H;
      end
      mip = 0;
      while (mip < 30 && (64'd6 << (2 * mip)) < 2 * area) begin
         mip++;
      end
      lvl = LOG_MAX - mip;
      if (lvl < 0) begin
         lvl = 0;
      end
      if (!reallocate_on) begin
         return '0;
      end
      if (lvl > int'(cfata_pkg::MAX_LEVEL)) begin
         return cfata_pkg::MAX_LEVEL;
      end
      return lvl[cfata_pkg::LEVEL_W-1:0];
   endfunction

   // A candidate square is free when it overlaps the tile of no other placed
   // face. The face being placed never blocks itself.
   function automatic bit spot_is_free(int f, int x, int y, int span);
      for (int p = 0; p < cfata_pkg::NUM_FACES; p++) begin
         if (p != f && face_placed[p] &&
             y < face_y[p] + face_size[p] && x < face_x[p] + face_size[p] &&
             y + span > face_y[p] && x + span > face_x[p]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // First fit with columns outer and rows inner, on a grid of the current
   // tile edge. A face that already holds a tile keeps it.
   function automatic bit place_face(int f);
      int tile_edge;
      if (face_placed[f]) begin
         return 1'b1;
      end
      tile_edge = 1 << (LOG_MAX - int'(atlas_level));
      for (int x = 0; x < ATLAS_W; x += tile_edge) begin
         for (int y = 0; y < ATLAS_H; y += tile_edge) begin
            if (spot_is_free(f, x, y, tile_edge)) begin
               face_placed[f] = 1'b1;
               face_x[f]      = x;
               face_y[f]      = y;
               face_size[f]   = tile_edge;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Advances the predictor by one command and returns the reply it expects.
   function automatic tile_reply_type predict_reply(atlas_command_type cmd);
      tile_reply_type reply;
      reply = '0;
      unique case (cmd.action)
         cfata_pkg::ACT_SET_BOUNDS: begin
            atlas_level = level_for_rect(cmd.width, cmd.height);
         end
         cfata_pkg::ACT_CLEAR: begin
            if (reallocate_on) begin
               face_placed = '{default: 1'b0};
            end
         end
         cfata_pkg::ACT_ALLOCATE: begin
            if (int'(cmd.face) >= cfata_pkg::NUM_FACES || !place_face(int'(cmd.face))) begin
               reply.status = cfata_pkg::STATUS_NO_SPACE;
            end else begin
               reply.tile_x    = face_x[cmd.face][cfata_pkg::TILE_X_W-1:0];
               reply.tile_y    = face_y[cmd.face][cfata_pkg::TILE_Y_W-1:0];
               reply.tile_size = face_size[cmd.face][cfata_pkg::TILE_SIZE_W-1:0];
            end
         end
         default: begin
         end
      endcase
      reply.level = atlas_level;
      return reply;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic void add_row(logic [cfata_pkg::ACTION_W-1:0] action,
                                   logic [cfata_pkg::FACE_W-1:0] face,
                                   logic [cfata_pkg::RECT_W-1:0] w,
                                   logic [cfata_pkg::RECT_W-1:0] h,
                                   bit typed = 1'b0,
                                   cfata_pkg::status_type st = cfata_pkg::STATUS_OK,
                                   int x = 0, int y = 0, int size = 0, int level = 0);
      atlas_command_type cmd;
      cmd.action          = action;
      cmd.face            = face;
      cmd.width           = w;
      cmd.height          = h;
      cmd.typed           = typed;
      cmd.reply.status    = st;
      cmd.reply.tile_x    = x[cfata_pkg::TILE_X_W-1:0];
      cmd.reply.tile_y    = y[cfata_pkg::TILE_Y_W-1:0];
      cmd.reply.tile_size = size[cfata_pkg::TILE_SIZE_W-1:0];
      cmd.reply.level     = level[cfata_pkg::LEVEL_W-1:0];
      directed_rows.push_back(cmd);
   endfunction

   // Rectangle edges: full range for the bit patterns and saturation, small
   // edges so that every detail level gets chosen, the saturation point and all ones.
   function automatic logic [cfata_pkg::RECT_W-1:0] random_extent();
      int          roll;
      int unsigned pick;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         pick = $urandom_range(0, (1 << cfata_pkg::RECT_W) - 1);
         return pick[cfata_pkg::RECT_W-1:0];
      end else if (roll < 90) begin
         pick = $urandom_range(0, 600);
         return pick[cfata_pkg::RECT_W-1:0];
      end else if (roll < 95) begin
         return cfata_pkg::RECT_SAT;
      end
      return '1;
   endfunction

   // Mostly allocations, with enough bounds changes and clears to keep the
   // faces moving between tile sizes. A few bad faces and unused codes.
   function automatic atlas_command_type random_command();
      atlas_command_type cmd;
      int                roll;
      int unsigned       pick;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         cmd.action = cfata_pkg::ACT_SET_BOUNDS;
      end else if (roll < 28) begin
         cmd.action = cfata_pkg::ACT_CLEAR;
      end else if (roll < 95) begin
         cmd.action = cfata_pkg::ACT_ALLOCATE;
      end else begin
         cmd.action = ACT_UNUSED;
      end
      if ($urandom_range(0, 99) < 92) begin
         pick = $urandom_range(0, cfata_pkg::NUM_FACES - 1);
      end else begin
         pick = $urandom_range(cfata_pkg::NUM_FACES, 7);
      end
      cmd.face   = pick[cfata_pkg::FACE_W-1:0];
      cmd.width  = random_extent();
      cmd.height = random_extent();
      cmd.typed  = 1'b0;
      cmd.reply  = '0;
      return cmd;
   endfunction

   // Sender gaps: mostly none or short, sometimes long, and a stretch of
   // back-to-back transfers at the start of every hundred commands.
   function automatic int pick_gap(int idx);
      int roll;
      roll = $urandom_range(0, 99);
      if ((idx % 100) < 20 || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   // Presents one command and holds it until the block takes it. Valid stays
   // high into the next command when there is no gap. The expectation is
   // recorded at the accepting edge, well before its reply can appear.
   task automatic send_command(input atlas_command_type cmd, input int gap);
      tile_reply_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= cmd.action;
      req_face        <= cmd.face;
      req_rect_width  <= cmd.width;
      req_rect_height <= cmd.height;
      do begin
         @(posedge clock);
      end while (req_stall);
      predicted = predict_reply(cmd);
      pending_replies.push_back(cmd.typed ? cmd.reply : predicted);
   endtask

   // Stops sending and waits until every reply has come back. Each command
   // has exactly one reply, so the block is idle afterwards.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reallocate(input bit enable);
      csr_write_enable <= 1'b1;
      csr_write_data   <= enable;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reallocate_on     = enable;
   endtask

   // ------------------------------------------------------------------------
   // Response side: checks every transfer against the oldest expectation and
   // throttles the block with random stalls, long stalls and calm stretches.
   // ------------------------------------------------------------------------
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   int stall_left = 0;
   int calm_left  = 0;
   int stall_roll = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: reply transfer with none expected, actual status %0d x %0d",
                     $time, rsp_status, rsp_tile_x);
            $display("%0t: actual y %0d size %0d level %0d",
                     $time, rsp_tile_y, rsp_tile_size, rsp_detail_level);
            mismatch_count++;
         end else begin
            oldest_reply = pending_replies.pop_front();
            compare_field("status", 32'(oldest_reply.status), 32'(rsp_status));
            compare_field("tile_x", 32'(oldest_reply.tile_x), 32'(rsp_tile_x));
            compare_field("tile_y", 32'(oldest_reply.tile_y), 32'(rsp_tile_y));
            compare_field("tile_size", 32'(oldest_reply.tile_size), 32'(rsp_tile_size));
            compare_field("detail_level", 32'(oldest_reply.level), 32'(rsp_detail_level));
         end
      end

      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 94) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else if (stall_roll < 97) begin
            stall_left = $urandom_range(10, 50);
            rsp_stall <= 1'b1;
         end else begin
            calm_left = $urandom_range(50, 300);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a run in which neither channel moves for too long is hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      // Directed table, run right after reset with reallocation on. Rows
      // with a typed reply can be read straight off the placement rules.
      // The first face lands in the corner as a 512 tile at level 0.
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd0, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 512, 0);
      // A face that already holds a tile gets the same tile back.
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd0, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 512, 0);
      // Faces beyond the sixth are refused and change nothing.
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd6, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_NO_SPACE, 0, 0, 0, 0);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd7, 14'h3FFF, 14'h3FFF,
              1'b1, cfata_pkg::STATUS_NO_SPACE, 0, 0, 0, 0);
      // The unused code is answered with an empty reply.
      add_row(ACT_UNUSED, 3'd7, 14'h3FFF, 14'h3FFF,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 0);
      // An empty rectangle asks for the finest level, limited to 3.
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 3);
      // Saturated edges cap the area at the atlas and drive the level to 0.
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd5, 14'h3FFF, 14'h3FFF,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 0);
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd8192, 14'd1,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 3);
      // 64 tiles must step below the 512 tile in the first column.
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd1, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 512, 64, 3);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd5, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 576, 64, 3);
      // Middle levels and a mix of tile sizes.
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd300, 14'd300);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd2, 14'd0, 14'd0);
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd150, 14'd150);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd3, 14'd0, 14'd0);
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd8193, 14'd8192,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 0);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd4, 14'd0, 14'd0);
      // Clear frees every face, so the next one gets the corner again.
      add_row(cfata_pkg::ACT_CLEAR, 3'd0, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 0, 0);
      add_row(cfata_pkg::ACT_ALLOCATE, 3'd4, 14'd0, 14'd0,
              1'b1, cfata_pkg::STATUS_OK, 0, 0, 512, 0);
      // Alternating bit patterns on the rectangle, then fill all six faces.
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'h2AAA, 14'h1555);
      add_row(cfata_pkg::ACT_SET_BOUNDS, 3'd0, 14'd200, 14'd100);
      for (int f = 0; f < cfata_pkg::NUM_FACES; f++) begin
         add_row(cfata_pkg::ACT_ALLOCATE, f[cfata_pkg::FACE_W-1:0], 14'd0, 14'd0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_command(directed_rows[r], pick_gap(r));
      end

      // Random phases alternate reallocation off and on, so both register
      // values are seen with faces already placed. Each register write waits
      // for the block to drain, and each phase also pauses once halfway.
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_replies();
         repeat (2) @(posedge clock);
         write_reallocate((phase % 2) == 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) begin
               wait_for_replies();
            end
            send_command(random_command(), pick_gap(i));
         end
      end

      // Drain, then give the block a full scan's worth of time to show any
      // reply that it should not produce.
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/cfata_pkg.sv
sv/cfata_level_unit.sv
sv/cfata_overlap_check.sv
sv/cube_face_atlas_tile_allocator_unit.sv
tb/sv/cube_face_atlas_tile_allocator_unit_tb.sv
